FILE: sv/imgpkt_pkg.sv
// ----------------------------------------------------------------------------
// imgpkt_pkg
// Shared types, constants and helpers of the image stream packetizer.
// ----------------------------------------------------------------------------
package imgpkt_pkg;

  localparam int unsigned DataW          = 8;
  localparam int unsigned ImgW           = 24;
  localparam int unsigned SegW           = 15;
  localparam int unsigned LenW           = 14;
  localparam int unsigned HdrBytes       = 10;
  localparam int unsigned PacketBytesDef = 1024;

  localparam logic [ImgW-1:0] ImageBytesRst = 24'd921600;

  // reciprocals for constant division of small values
  localparam logic [14:0] Recip1000 = 15'd16778;  // ceil(2^24 / 1000)
  localparam logic [10:0] Recip100  = 11'd1311;   // ceil(2^17 / 100)
  localparam logic [6:0]  Recip10   = 7'd103;     // ceil(2^10 / 10)

  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharI     = 8'h49;
  localparam logic [7:0] CharX     = 8'h58;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpA   = 8'h41;

  // position inside the header; HdrData means the payload byte goes out
  typedef enum logic [3:0] {
    HdrD0,
    HdrI,
    HdrD1,
    HdrSegHi,
    HdrSegMid,
    HdrSegLo,
    HdrLenTh,
    HdrLenHu,
    HdrLenTe,
    HdrLenOn,
    HdrData
  } hdr_pos_e;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             need_hdr;
    logic [SegW-1:0]  seg;
    logic [LenW-1:0]  len;
    logic             last_pkt;
    logic             last_img;
  } imgpkt_item_t;

  function automatic logic [7:0] hex_char(input logic [6:0] v);
    logic [7:0] c;
    if (v < 7'd10) begin
      c = CharZero + 8'(v);
    end else if (v < 7'd16) begin
      c = CharUpA + 8'(v - 7'd10);
    end else begin
      c = CharX;
    end
    return c;
  endfunction

  function automatic logic [7:0] dec_char(input logic [3:0] d);
    return CharZero + 8'(d);
  endfunction

endpackage

FILE: sv/imgpkt_if.sv
// ----------------------------------------------------------------------------
// imgpkt interfaces
// Valid/ready channels for image bytes in, packet bytes out and the
// frame length register write.
// ----------------------------------------------------------------------------
interface imgpkt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface imgpkt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       image_end;

  modport source (output valid, output out_byte, output packet_end, output image_end,
                  input ready);
  modport sink   (input valid, input out_byte, input packet_end, input image_end,
                  output ready);
endinterface

interface imgpkt_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] image_bytes;

  modport source (output valid, output image_bytes, input ready);
  modport sink   (input valid, input image_bytes, output ready);
endinterface

FILE: sv/imgpkt_ctrl.sv
// ----------------------------------------------------------------------------
// imgpkt_ctrl
// Frame and packet bookkeeping: takes image bytes, tracks the counters and
// hands each byte with its header info and end flags to the emitter.
// ----------------------------------------------------------------------------
module imgpkt_ctrl #(
  parameter int unsigned PacketBytes = imgpkt_pkg::PacketBytesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  imgpkt_in_if.sink                in_i,
  imgpkt_cfg_if.sink               cfg_i,
  output imgpkt_pkg::imgpkt_item_t item_o,
  output logic                     item_valid_o,
  input  logic                     item_pop_i
);
  import imgpkt_pkg::*;

  localparam int unsigned MaxPayload = PacketBytes - HdrBytes;
  localparam int unsigned PosW       = $clog2(PacketBytes);

  logic [ImgW-1:0] img_bytes_q;
  logic [ImgW-1:0] done_q, done_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [SegW-1:0] seg_q, seg_d;
  logic            stg_valid_q, stg_valid_d;
  imgpkt_item_t    stg_q, stg_d;

  logic            accept;
  logic [ImgW:0]   diff;
  logic            has_rem;
  logic [ImgW-1:0] remaining;
  logic [LenW-1:0] payload;
  logic            last_img;
  logic            last_pkt;
  logic [PosW:0]   pos_inc;
  logic            need_hdr;
  logic [SegW-1:0] seg_cur;

  assign cfg_i.ready  = 1'b1;
  assign in_i.ready   = !stg_valid_q || item_pop_i;
  assign accept       = in_i.valid && in_i.ready;
  assign item_o       = stg_q;
  assign item_valid_o = stg_valid_q;

  always_comb begin
    diff      = {1'b0, img_bytes_q} - {1'b0, done_q};
    has_rem   = !diff[ImgW] && (diff != '0);
    remaining = has_rem ? diff[ImgW-1:0] : ImgW'(1);
    payload   = (remaining < ImgW'(MaxPayload)) ? remaining[LenW-1:0] : LenW'(MaxPayload);
    // last image byte when at most one byte is left, or already past the end
    last_img  = diff[ImgW] || (diff <= (ImgW+1)'(1));
    pos_inc   = {1'b0, pos_q} + (PosW+1)'(1);
    last_pkt  = last_img || (pos_inc >= (PosW+1)'(MaxPayload));
    need_hdr  = (pos_q == '0);
    seg_cur   = need_hdr ? (seg_q + SegW'(1)) : seg_q;

    done_d      = done_q;
    pos_d       = pos_q;
    seg_d       = seg_q;
    stg_d       = stg_q;
    stg_valid_d = stg_valid_q;

    if (item_pop_i) begin
      stg_valid_d = 1'b0;
    end

    if (accept) begin
      stg_valid_d    = 1'b1;
      stg_d.data     = in_i.data_byte;
      stg_d.need_hdr = need_hdr;
      stg_d.seg      = seg_cur;
      stg_d.len      = payload + LenW'(HdrBytes);
      stg_d.last_pkt = last_pkt;
      stg_d.last_img = last_img;
      if (last_img) begin
        done_d = '0;
        pos_d  = '0;
        seg_d  = '0;
      end else begin
        done_d = done_q + ImgW'(1);
        pos_d  = last_pkt ? '0 : pos_inc[PosW-1:0];
        seg_d  = seg_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_bytes_q <= ImageBytesRst;
      done_q      <= '0;
      pos_q       <= '0;
      seg_q       <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        img_bytes_q <= cfg_i.image_bytes;
      end
      done_q      <= done_d;
      pos_q       <= pos_d;
      seg_q       <= seg_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

endmodule

FILE: sv/imgpkt_emit.sv
// ----------------------------------------------------------------------------
// imgpkt_emit
// Header sequencer and output byte register: sends the ten header characters
// ahead of the first byte of a packet, then the byte itself.
// ----------------------------------------------------------------------------
module imgpkt_emit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  imgpkt_pkg::imgpkt_item_t item_i,
  input  logic                     item_valid_i,
  output logic                     item_pop_o,
  imgpkt_out_if.source             out_o
);
  import imgpkt_pkg::*;

  hdr_pos_e   pos_q, pos_d;
  logic [9:0] rem_q, rem_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       pend_q, pend_d;
  logic       iend_q, iend_d;

  logic       load;
  logic       adv;
  logic       is_data;

  logic [28:0] p1;
  logic [3:0]  d1;
  logic [20:0] p2;
  logic [3:0]  d2;
  logic [13:0] p3;
  logic [3:0]  d3;

  assign load       = !out_valid_q || out_o.ready;
  assign adv        = item_valid_i && load;
  assign is_data    = !item_i.need_hdr || (pos_q == HdrData);
  assign item_pop_o = adv && is_data;

  // decimal digits of the packet length, one per header cycle while the output is not stalled
  assign p1 = 29'(item_i.len) * 29'(Recip1000);
  assign d1 = p1[27:24];
  assign p2 = 21'(rem_q) * 21'(Recip100);
  assign d2 = p2[20:17];
  assign p3 = 14'(rem_q[6:0]) * 14'(Recip10);
  assign d3 = p3[13:10];

  always_comb begin
    pos_d       = pos_q;
    rem_d       = rem_q;
    byte_d      = byte_q;
    pend_d      = pend_q;
    iend_d      = iend_q;
    out_valid_d = out_valid_q;

    if (load) begin
      out_valid_d = item_valid_i;
    end

    if (adv) begin
      pend_d = 1'b0;
      iend_d = 1'b0;
      if (is_data) begin
        byte_d = item_i.data;
        pend_d = item_i.last_pkt;
        iend_d = item_i.last_img;
        pos_d  = HdrD0;
      end else begin
        pos_d = hdr_pos_e'(pos_q + 4'd1);
        case (pos_q)
          HdrD0:     byte_d = CharD;
          HdrI:      byte_d = CharI;
          HdrD1:     byte_d = CharD;
          HdrSegHi:  byte_d = hex_char(item_i.seg[14:8]);
          HdrSegMid: byte_d = hex_char({3'b000, item_i.seg[7:4]});
          HdrSegLo:  byte_d = hex_char({3'b000, item_i.seg[3:0]});
          HdrLenTh: begin
            byte_d = dec_char(d1);
            rem_d  = 10'(item_i.len - 14'(d1) * 14'd1000);
          end
          HdrLenHu: begin
            byte_d = dec_char(d2);
            rem_d  = rem_q - 10'(d2) * 10'd100;
          end
          HdrLenTe: begin
            byte_d = dec_char(d3);
            rem_d  = 10'(rem_q[6:0] - 7'(d3) * 7'd10);
          end
          HdrLenOn:  byte_d = dec_char(rem_q[3:0]);
          default:   byte_d = item_i.data;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= HdrD0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    byte_q <= byte_d;
    pend_q <= pend_d;
    iend_q <= iend_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.packet_end = pend_q;
  assign out_o.image_end  = iend_q;

endmodule

FILE: sv/image_stream_packetizer.sv
// ----------------------------------------------------------------------------
// image_stream_packetizer
// Cuts an image byte stream into packets with a ten-character ASCII header.
// ----------------------------------------------------------------------------
//   channel  direction  payload                              handshake
//   in_i     sink       data_byte[7:0]                       valid/ready
//   out_o    source     out_byte[7:0], packet_end, image_end valid/ready
//   cfg_i    sink       image_bytes[23:0]                    valid/ready, ready=1
//
// one output byte per cycle while out_o is ready; the first byte of a packet
// waits behind its ten header bytes, which share the single output byte
// register ahead of it
// input register and output register each hold one byte, so a byte is taken
// while the previous one waits at the output
// reset clears the counters and both valid flags; image_bytes resets to 921600
// ----------------------------------------------------------------------------
module image_stream_packetizer #(
  parameter int unsigned PacketBytes = imgpkt_pkg::PacketBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  imgpkt_in_if.sink    in_i,
  imgpkt_out_if.source out_o,
  imgpkt_cfg_if.sink   cfg_i
);
  import imgpkt_pkg::*;

  imgpkt_item_t item;
  logic         item_valid;
  logic         item_pop;

  imgpkt_ctrl #(
    .PacketBytes (PacketBytes)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  imgpkt_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_o        (out_o)
  );

endmodule

FILE: dv/image_stream_packetizer_tb.sv
// ----------------------------------------------------------------------------
// image_stream_packetizer_tb
// Self-checking bench for the image stream packetizer. Image bytes go in
// through bursts with random gaps while the packet side stalls on its own
// pattern. Every packet byte that comes out, including the ASCII header, is
// compared with a local model of the header and packet/image framing. A
// short table of directed cases runs first, followed by random frames.
// ----------------------------------------------------------------------------
module image_stream_packetizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imgpkt_pkg::*;

  localparam int unsigned PacketBytes = PacketBytesDef;
  localparam int unsigned MaxPayload  = PacketBytes - HdrBytes;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned SmallItems  = 240;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
    logic       image_end;
  } pkt_byte_t;

  typedef enum logic {RowByte, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [23:0] value;
    logic        chk;
    logic        pend;
    logic        iend;
  } stim_row_t;

  localparam int NumDirRows = 21;

  // chk rows carry the framing flags of the payload byte, typed in by hand
  stim_row_t dir_rows [NumDirRows] = '{
    '{RowByte, 24'h000000, 1'b1, 1'b0, 1'b0},  // first byte after reset
    '{RowByte, 24'h0000FF, 1'b1, 1'b0, 1'b0},
    '{RowCfg,  24'hFFFFFF, 1'b0, 1'b0, 1'b0},  // largest frame, mid packet
    '{RowByte, 24'h000055, 1'b0, 1'b0, 1'b0},
    '{RowCfg,  24'h000001, 1'b0, 1'b0, 1'b0},  // shrink below bytes already done
    '{RowByte, 24'h0000AA, 1'b1, 1'b1, 1'b1},
    '{RowByte, 24'h000001, 1'b1, 1'b1, 1'b1},  // one-byte frames
    '{RowByte, 24'h000080, 1'b1, 1'b1, 1'b1},
    '{RowCfg,  24'h000003, 1'b0, 1'b0, 1'b0},
    '{RowByte, 24'h00007F, 1'b1, 1'b0, 1'b0},
    '{RowByte, 24'h0000FE, 1'b1, 1'b0, 1'b0},
    '{RowByte, 24'h000002, 1'b1, 1'b1, 1'b1},
    '{RowCfg,  24'h000005, 1'b0, 1'b0, 1'b0},
    '{RowByte, 24'h000010, 1'b0, 1'b0, 1'b0},
    '{RowByte, 24'h000020, 1'b0, 1'b0, 1'b0},
    '{RowByte, 24'h000040, 1'b0, 1'b0, 1'b0},
    '{RowCfg,  24'h000002, 1'b0, 1'b0, 1'b0},  // length already passed
    '{RowByte, 24'h000004, 1'b1, 1'b1, 1'b1},
    '{RowByte, 24'h000008, 1'b1, 1'b0, 1'b0},
    '{RowByte, 24'h0000C3, 1'b1, 1'b1, 1'b1},
    '{RowCfg,  24'h000007, 1'b0, 1'b0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  imgpkt_in_if  in_if ();
  imgpkt_out_if out_if ();
  imgpkt_cfg_if cfg_if ();

  image_stream_packetizer #(
    .PacketBytes (PacketBytes)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // local copy of the framing state
  logic [23:0] img_bytes_q;
  logic [23:0] done_q;
  logic [13:0] pos_q;
  logic [14:0] seg_q;

  pkt_byte_t packet_bytes_q[$];

  int unsigned mismatch_cnt = 0;
  int unsigned sent_cnt     = 0;
  int unsigned pkt_cnt      = 0;
  int unsigned img_cnt      = 0;
  int unsigned cfg_cnt      = 0;
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b1;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] seg_digit(input int unsigned v);
    if (v < 10) return CharZero + 8'(v);
    if (v < 16) return CharUpA + 8'(v - 10);
    return CharX;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic pe, input logic ie);
    pkt_byte_t e;
    e.out_byte   = b;
    e.packet_end = pe;
    e.image_end  = ie;
    packet_bytes_q.push_back(e);
  endfunction

  // expected packet bytes for one accepted image byte
  function automatic void predict_packet_bytes(input logic [7:0] b);
    int unsigned remaining;
    int unsigned payload;
    int unsigned len;
    int unsigned seg;
    int unsigned done_nx;
    logic        last_img;
    logic        last_pkt;
    if (pos_q == '0) begin
      remaining = (img_bytes_q > done_q) ? int'(img_bytes_q - done_q) : 1;
      payload   = (remaining < MaxPayload) ? remaining : MaxPayload;
      len       = payload + HdrBytes;
      seg_q     = seg_q + 15'd1;
      seg       = seg_q;
      queue_byte(CharD, 1'b0, 1'b0);
      queue_byte(CharI, 1'b0, 1'b0);
      queue_byte(CharD, 1'b0, 1'b0);
      queue_byte(seg_digit(seg / 256), 1'b0, 1'b0);
      queue_byte(seg_digit((seg / 16) % 16), 1'b0, 1'b0);
      queue_byte(seg_digit(seg % 16), 1'b0, 1'b0);
      queue_byte(CharZero + 8'((len / 1000) % 10), 1'b0, 1'b0);
      queue_byte(CharZero + 8'((len % 1000) / 100), 1'b0, 1'b0);
      queue_byte(CharZero + 8'((len % 100) / 10), 1'b0, 1'b0);
      queue_byte(CharZero + 8'(len % 10), 1'b0, 1'b0);
    end
    done_nx  = done_q + 1;
    last_img = (done_nx >= img_bytes_q);
    pos_q    = pos_q + 14'd1;
    done_q   = done_q + 24'd1;
    last_pkt = last_img || (pos_q >= MaxPayload);
    queue_byte(b, last_pkt, last_img);
    if (last_img) begin
      done_q = '0;
      pos_q  = '0;
      seg_q  = '0;
    end else if (last_pkt) begin
      pos_q = '0;
    end
  endfunction

  // offer one image byte, wait for the transaction, then maybe idle a while
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    predict_packet_bytes(b);
    sent_cnt++;
    if (burst_left == 0) begin
      gap        = gaps_on ? $urandom_range(1, 8) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_packets();
    in_if.valid <= 1'b0;
    while (packet_bytes_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_image_bytes(input logic [23:0] v);
    drain_packets();
    cfg_if.valid       <= 1'b1;
    cfg_if.image_bytes <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    img_bytes_q = v;
    cfg_cnt++;
  endtask

  // send until the current frame closes
  task automatic finish_frame();
    do send_byte(8'($urandom_range(0, 255))); while (done_q != '0);
  endtask

  // packet side: stall pattern of its own plus one long hold-off on request
  initial begin : out_stall
    int unsigned win_cnt;
    int unsigned stall_mode;
    win_cnt    = 0;
    stall_mode = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (win_cnt == 0) begin
          stall_mode = $urandom_range(0, 3);
          win_cnt    = $urandom_range(20, 80);
        end
        win_cnt--;
        case (stall_mode)
          0: begin
            out_if.ready <= 1'b1;
          end
          1: begin
            out_if.ready <= ($urandom_range(0, 1) == 0);
          end
          2: begin
            out_if.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_if.ready <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    pkt_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (packet_bytes_q.size() == 0) begin
        $error("unexpected packet byte %h (packet_end %b, image_end %b)",
               out_if.out_byte, out_if.packet_end, out_if.image_end);
        mismatch_cnt++;
      end else begin
        want = packet_bytes_q.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_if.out_byte);
          mismatch_cnt++;
        end
        if (out_if.packet_end !== want.packet_end) begin
          $error("packet_end: expected %b, got %b", want.packet_end, out_if.packet_end);
          mismatch_cnt++;
        end
        if (out_if.image_end !== want.image_end) begin
          $error("image_end: expected %b, got %b", want.image_end, out_if.image_end);
          mismatch_cnt++;
        end
      end
      if (out_if.packet_end === 1'b1) pkt_cnt++;
      if (out_if.image_end === 1'b1) img_cnt++;
    end
  end

  initial begin : run_limit
    #5ms;
    $display("timeout with %0d packet bytes outstanding", packet_bytes_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    pkt_byte_t   tail;
    int unsigned small_cnt;
    int unsigned frame_len;
    int unsigned part_len;
    in_if.valid        <= 1'b0;
    in_if.data_byte    <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.image_bytes <= '0;
    rst_ni             <= 1'b0;
    img_bytes_q = ImageBytesRst;
    done_q      = '0;
    pos_q       = '0;
    seg_q       = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NumDirRows; i++) begin
      if (dir_rows[i].kind == RowCfg) begin
        write_image_bytes(dir_rows[i].value);
      end else begin
        send_byte(dir_rows[i].value[7:0]);
        if (dir_rows[i].chk) begin
          tail = packet_bytes_q.pop_back();
          tail.packet_end = dir_rows[i].pend;
          tail.image_end  = dir_rows[i].iend;
          packet_bytes_q.push_back(tail);
        end
      end
    end
    finish_frame();

    // long hold-off on the packet side while a frame keeps coming in
    write_image_bytes(24'd40);
    hold_req = 1'b1;
    finish_frame();

    // short random frames, some resized part way through
    small_cnt = 0;
    while (small_cnt < SmallItems) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      frame_len = $urandom_range(1, 48);
      write_image_bytes(24'(frame_len));
      if (frame_len > 1 && $urandom_range(0, 3) == 0) begin
        part_len = $urandom_range(1, frame_len - 1);
        repeat (part_len) send_byte(8'($urandom_range(0, 255)));
        small_cnt += part_len;
        write_image_bytes(24'($urandom_range(1, part_len + 20)));
      end
      part_len = sent_cnt;
      finish_frame();
      small_cnt += sent_cnt - part_len;
    end

    drain_packets();
    repeat (20) @(posedge clk_i);
    $display("sent %0d image bytes with %0d length writes", sent_cnt, cfg_cnt);
    $display("checked %0d packets across %0d complete frames", pkt_cnt, img_cnt);
    if (mismatch_cnt == 0 && packet_bytes_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/imgpkt_pkg.sv
sv/imgpkt_if.sv
sv/imgpkt_ctrl.sv
sv/imgpkt_emit.sv
sv/image_stream_packetizer.sv
dv/image_stream_packetizer_tb.sv
